>>> rtl/core/hse_pkg.sv
package hse_pkg;

  localparam int CAPACITY = 64;
  localparam int POS_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CHILD_W  = POS_W + 1;
  localparam int KEY_W    = 32;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic                    last_key;
  } item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] sorted_key;
    logic                    last_out;
    logic                    overflow;
  } result_t;

  // true when a must sit above b in the heap
  function automatic logic ranks_above(input logic dir,
                                       input logic signed [KEY_W-1:0] a,
                                       input logic signed [KEY_W-1:0] b);
    ranks_above = dir ? (a < b) : (a > b);
  endfunction

endpackage

>>> rtl/core/hse_ram.sv
module hse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/hse_front.sv
module hse_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  hse_pkg::item_t item,
  output logic          avail,
  input  logic          take,
  output hse_pkg::item_t head
);
  import hse_pkg::*;

  // two-entry request queue
  item_t      slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_take;

  assign full    = (fill == 2'd2);
  assign avail   = (fill != 2'd0);
  assign head    = slot[rd_ptr];
  assign do_push = push && !full;
  assign do_take = take && avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= item;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_take) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, do_push} - {1'b0, do_take};
    end
  end

endmodule

>>> rtl/core/hse_back.sv
module hse_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           direction,
  input  logic           avail,
  output logic           take,
  input  hse_pkg::item_t head,
  output logic           empty,
  input  logic           pop,
  output hse_pkg::result_t result
);
  import hse_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_RD  = 4'd1;
  localparam logic [3:0] S_INS_CMP = 4'd2;
  localparam logic [3:0] S_EX_RD1  = 4'd3;
  localparam logic [3:0] S_EX_RD2  = 4'd4;
  localparam logic [3:0] S_EX_SET  = 4'd5;
  localparam logic [3:0] S_EX_CHK  = 4'd6;
  localparam logic [3:0] S_EX_C1   = 4'd7;
  localparam logic [3:0] S_EX_C2   = 4'd8;
  localparam logic [3:0] S_EX_CMP  = 4'd9;
  localparam logic [3:0] S_EX_FIN  = 4'd10;
  localparam logic [3:0] S_EX_PUT  = 4'd11;
  localparam logic [3:0] S_EM_RD   = 4'd12;
  localparam logic [3:0] S_EM_LD   = 4'd13;

  logic [3:0]              state;
  logic [POS_W-1:0]        count;
  logic                    ovf;
  logic signed [KEY_W-1:0] cur;      // key being inserted, or moved key on extraction
  logic signed [KEY_W-1:0] top;
  logic signed [KEY_W-1:0] best;
  logic                    last;
  logic [POS_W-1:0]        pos;      // insert position, or parent on sift down
  logic [CHILD_W-1:0]      child;
  logic [POS_W-1:0]        top_pos;
  logic [POS_W-1:0]        run_n;
  logic [POS_W-1:0]        idx;
  logic                    out_valid;
  result_t                 out_reg;

  logic                    we;
  logic [ADDR_W-1:0]       waddr;
  logic [KEY_W-1:0]        wdata;
  logic [ADDR_W-1:0]       raddr;
  logic [KEY_W-1:0]        rdata;
  logic [POS_W-1:0]        parent_pos;
  logic [POS_W-1:0]        rd_pos;
  logic [POS_W-1:0]        wr_pos;
  logic                    out_free;
  logic                    child_in;

  hse_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign parent_pos = pos >> 1;
  assign out_free   = !out_valid || pop;
  assign child_in   = (child <= {1'b0, count});
  assign empty      = !out_valid;
  assign result     = out_reg;
  assign take       = (state == S_IDLE) && avail;

  always_comb begin
    rd_pos = parent_pos;
    case (state)
      S_INS_RD: rd_pos = parent_pos;
      S_EX_RD1: rd_pos = POS_W'(1);
      S_EX_RD2: rd_pos = count;
      S_EX_CHK: rd_pos = child[POS_W-1:0];
      S_EX_C1:  rd_pos = POS_W'(child + CHILD_W'(1));
      S_EM_RD:  rd_pos = idx;
      default:  rd_pos = parent_pos;
    endcase
    raddr = ADDR_W'(rd_pos - POS_W'(1));
  end

  always_comb begin
    we     = 1'b0;
    wr_pos = pos;
    wdata  = cur;
    case (state)
      S_INS_RD: begin
        if (pos == POS_W'(1)) begin
          we = 1'b1;
        end
      end
      S_INS_CMP: begin
        we = 1'b1;
        if (ranks_above(direction, cur, rdata)) begin
          wdata = rdata;
        end
      end
      S_EX_CMP: begin
        if (ranks_above(direction, best, cur)) begin
          we    = 1'b1;
          wdata = best;
        end
      end
      S_EX_FIN: we = 1'b1;
      S_EX_PUT: begin
        we     = 1'b1;
        wr_pos = top_pos;
        wdata  = top;
      end
      default: we = 1'b0;
    endcase
    waddr = ADDR_W'(wr_pos - POS_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (avail) begin
            cur  <= head.key;
            last <= head.last_key;
            if (count == POS_W'(CAPACITY)) begin
              ovf <= 1'b1;
              if (head.last_key) begin
                run_n <= count;
                state <= S_EX_RD1;
              end
            end else begin
              pos   <= count + POS_W'(1);
              count <= count + POS_W'(1);
              state <= S_INS_RD;
            end
          end
        end
        S_INS_RD: begin
          if (pos == POS_W'(1)) begin
            run_n <= count;
            state <= last ? S_EX_RD1 : S_IDLE;
          end else begin
            state <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (ranks_above(direction, cur, rdata)) begin
            pos   <= parent_pos;
            state <= S_INS_RD;
          end else begin
            run_n <= count;
            state <= last ? S_EX_RD1 : S_IDLE;
          end
        end
        S_EX_RD1: state <= S_EX_RD2;
        S_EX_RD2: begin
          top   <= rdata;
          state <= S_EX_SET;
        end
        S_EX_SET: begin
          cur     <= rdata;
          top_pos <= count;
          count   <= count - POS_W'(1);
          pos     <= POS_W'(1);
          child   <= CHILD_W'(2);
          state   <= S_EX_CHK;
        end
        S_EX_CHK: state <= child_in ? S_EX_C1 : S_EX_FIN;
        S_EX_C1: begin
          best  <= rdata;
          state <= (child < {1'b0, count}) ? S_EX_C2 : S_EX_CMP;
        end
        S_EX_C2: begin
          if (ranks_above(direction, rdata, best)) begin
            best  <= rdata;
            child <= child + CHILD_W'(1);
          end
          state <= S_EX_CMP;
        end
        S_EX_CMP: begin
          if (ranks_above(direction, best, cur)) begin
            pos   <= child[POS_W-1:0];
            child <= {child[CHILD_W-2:0], 1'b0};
            state <= S_EX_CHK;
          end else begin
            state <= S_EX_FIN;
          end
        end
        S_EX_FIN: state <= S_EX_PUT;
        S_EX_PUT: begin
          idx   <= POS_W'(1);
          state <= (count == '0) ? S_EM_RD : S_EX_RD1;
        end
        S_EM_RD: begin
          if (out_free) begin
            state <= S_EM_LD;
          end
        end
        S_EM_LD: begin
          out_valid          <= 1'b1;
          out_reg.sorted_key <= rdata;
          out_reg.last_out   <= (idx == run_n);
          out_reg.overflow   <= ovf;
          idx                <= idx + POS_W'(1);
          if (idx == run_n) begin
            ovf   <= 1'b0;
            state <= S_IDLE;
          end else begin
            state <= S_EM_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/heap_sort_engine.sv
// insert: the key climbs one heap level per parent read (heap store read port)
// drain: each root goes to the heap end, the last key sifts down; then results go out
// one request in work at a time; a two-entry queue takes requests meanwhile
// loading: the next key is taken only once the sift-up loop of the last one is done
// reset: synchronous, clears heap count, overflow flag, direction and queues
module heap_sort_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             direction_we,
  input  logic             direction,
  input  logic             push,
  output logic             full,
  input  hse_pkg::item_t   item,
  output logic             empty,
  input  logic             pop,
  output hse_pkg::result_t result
);
  import hse_pkg::*;

  logic  dir;
  logic  avail;
  logic  take;
  item_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      dir <= 1'b0;
    end else if (direction_we) begin
      dir <= direction;
    end
  end

  hse_front u_front (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .item  (item),
    .avail (avail),
    .take  (take),
    .head  (head)
  );

  hse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .direction (dir),
    .avail     (avail),
    .take      (take),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule
